// ===== sv/aesort_pkg.sv =====
`timescale 1ns / 1ps

package aesort_pkg;

  localparam int unsigned DATA_W = 32;

  // One stored element of the chain
  typedef struct packed {
    logic                     used;
    logic signed [DATA_W-1:0] data;
  } slot_t;

  // Word carried from one cell to the next
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
  } carry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } sort_state_t;

endpackage

// ===== sv/aesort_cell.sv =====
`timescale 1ns / 1ps

module aesort_cell
  import aesort_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  carry_t carry_in,
  output carry_t carry_out,
  input  slot_t  next_slot,
  output slot_t  slot
);

  // Keep the smaller of held and incoming word, pass the larger on.
  // While shifting, take the neighbor's slot (unload toward cell 0).
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.used       <= 1'b0;
      carry_out.valid <= 1'b0;
    end else if (shift) begin
      slot            <= next_slot;
      carry_out.valid <= 1'b0;
    end else begin
      carry_out.valid <= 1'b0;
      if (carry_in.valid) begin
        if (!slot.used) begin
          slot.used <= 1'b1;
          slot.data <= carry_in.data;
        end else if (carry_in.data < slot.data) begin
          slot.data       <= carry_in.data;
          carry_out.valid <= 1'b1;
          carry_out.data  <= slot.data;
        end else begin
          carry_out.valid <= 1'b1;
          carry_out.data  <= carry_in.data;
        end
      end
    end
  end

endmodule

// ===== sv/ascending_exchange_sorter_core.sv =====
`timescale 1ns / 1ps
// Channel   | Signals                                    | Handshake
// ----------+--------------------------------------------+------------------------------
// input     | value[31:0] signed, last                   | taken when start && !busy
// result    | sorted_value[31:0] signed, end_of_set      | one cycle, marked by result_strobe
//
// Loading: one word per cycle, busy stays low until a word with last is taken.
// Each word enters cell 0 and ripples right through the insertion chain, one cell a cycle.
// After last, the chain settles in ST_SETTLE, then the n words kept (n <= DEPTH) are
// shifted out of cell 0 in ST_DRAIN, smallest first, with end_of_set on the final one.
// Words beyond DEPTH in a set are dropped. Reset clears the chain and the fill count.
// The receiver cannot stall; results are strobed once each.

module ascending_exchange_sorter_core
  import aesort_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  output logic                     result_strobe,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     end_of_set
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  sort_state_t      state, state_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic   accept;
  logic   full;
  logic   shift;
  carry_t carries [0:DEPTH];
  slot_t  slots   [0:DEPTH];

  assign accept = start && !busy;
  assign full   = (fill == DEPTH_C);

  // Word injected into the head of the chain
  assign carries[0].valid = accept && !full;
  assign carries[0].data  = value;
  assign slots[DEPTH]     = '0;

  // Insertion chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    aesort_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .carry_in  (carries[i]),
      .carry_out (carries[i+1]),
      .next_slot (slots[i+1]),
      .slot      (slots[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && last) state_next = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (cnt == ONE_C) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cnt == ONE_C) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Fill count and phase counter
  always_comb begin
    fill_next = fill;
    cnt_next  = cnt;
    case (state)
      ST_LOAD: begin
        if (accept && !full) fill_next = fill + ONE_C;
        if (accept && last)  cnt_next  = full ? fill : fill + ONE_C;
      end
      ST_SETTLE: begin
        cnt_next = (cnt == ONE_C) ? fill : cnt - ONE_C;
      end
      ST_DRAIN: begin
        cnt_next = cnt - ONE_C;
        if (cnt == ONE_C) fill_next = '0;
      end
      default: begin
        fill_next = '0;
        cnt_next  = '0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    busy          = 1'b1;
    shift         = 1'b0;
    result_strobe = 1'b0;
    end_of_set    = 1'b0;
    case (state)
      ST_LOAD: begin
        busy = 1'b0;
      end
      ST_SETTLE: begin
        busy = 1'b1;
      end
      ST_DRAIN: begin
        shift         = 1'b1;
        result_strobe = 1'b1;
        end_of_set    = (cnt == ONE_C);
      end
      default: busy = 1'b1;
    endcase
  end

  assign sorted_value = slots[0].data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      fill  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== test/sort_check_pkg.sv =====
`timescale 1ns / 1ps

package sort_check_pkg;

  import aesort_pkg::DATA_W;

  // One sorted word as it should leave the block
  typedef struct {
    logic signed [DATA_W-1:0] data;
    bit                       eos;
  } sorted_word_t;

  class sort_scoreboard;
    int unsigned              cap;
    logic signed [DATA_W-1:0] held[$];
    sorted_word_t             due[$];

    function new(int unsigned depth);
      cap = depth;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // Collect one accepted word; on last, sort the set and queue its results
    function void note_word(logic signed [DATA_W-1:0] v, bit l);
      sorted_word_t             w;
      logic signed [DATA_W-1:0] t;
      int                       j;
      // words past the store capacity are dropped, the last flag still counts
      if (held.size() < cap) held = {held, v};
      if (!l) return;
      // ascending signed insertion sort
      for (int i = 1; i < held.size(); i++) begin
        t = held[i];
        j = i - 1;
        while (j >= 0 && held[j] > t) begin
          held[j+1] = held[j];
          j--;
        end
        held[j+1] = t;
      end
      for (int k = 0; k < held.size(); k++) begin
        w.data = held[k];
        w.eos  = (k == held.size() - 1);
        due    = {due, w};
      end
      held.delete();
    endfunction

    // Compare one result word with the oldest expectation; empty string if it matches
    function string check_result(logic signed [DATA_W-1:0] v, logic e);
      sorted_word_t w;
      if (due.size() == 0)
        return $sformatf("result %0d eos %0b with no word pending", v, e);
      w = due.pop_front();
      if (v !== w.data || e !== w.eos)
        return $sformatf("got %0d eos %0b, want %0d eos %0b", v, e, w.data, w.eos);
      return "";
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  import aesort_pkg::*;
  import sort_check_pkg::*;

  localparam int unsigned SET_CAP       = 64;
  localparam int unsigned CYCLE_LIMIT   = 150000;
  localparam int unsigned SETTLE_CYCLES = 3 * SET_CAP + 16;
  localparam int unsigned RAND_TARGET   = 28;

  logic                     clk;
  logic                     rst   = 1'b1;
  logic                     start = 1'b0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     last  = 1'b0;
  logic                     busy;
  logic                     result_strobe;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     end_of_set;

  int unsigned    cycle_count = 0;
  int unsigned    mismatches  = 0;
  bit             burst_mode  = 1'b0;
  string          result_note;
  sort_scoreboard sb = new(SET_CAP);

  ascending_exchange_sorter_core #(.DEPTH(SET_CAP)) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .last         (last),
    .result_strobe(result_strobe),
    .sorted_value (sorted_value),
    .end_of_set   (end_of_set)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  // Result monitor and cycle counter
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && result_strobe) begin
      result_note = sb.check_result(sorted_value, end_of_set);
      if (result_note != "") report_mismatch(result_note);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Mix of full-range, small clustered and boundary values
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return $signed($urandom_range(0, 7)) - 4;
      3: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return '0;
          default: return -1;
        endcase
      end
      4:       return 32'sh8000_0000 + $urandom_range(0, 3);
      default: return 32'sh7fff_ffff - $urandom_range(0, 3);
    endcase
  endfunction

  // Drive one word and hold it until the block takes it
  task automatic send_word(input logic signed [DATA_W-1:0] v, input bit l);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    last  <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(v, l);
  endtask

  task automatic send_set(input int unsigned n);
    burst_mode = ($urandom_range(0, 2) == 0);
    for (int unsigned i = 0; i < n; i++) send_word(pick_value(), i == n - 1);
  endtask

  // Hold off until every queued result has come out
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    logic signed [DATA_W-1:0] boundary_words[8];
    logic signed [DATA_W-1:0] dup_words[4];
    int unsigned              rand_words;

    boundary_words = '{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 1,
                       32'sh5555_5555, 32'shaaaa_aaaa, 32'sh8000_0001};
    dup_words      = '{5, 5, -3, 5};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, single word set, duplicates, descending input
    burst_mode = 1'b1;
    foreach (boundary_words[i]) send_word(boundary_words[i], i == 7);
    send_word(32'sh1234_5678, 1'b1);
    burst_mode = 1'b0;
    foreach (dup_words[i]) send_word(dup_words[i], i == 3);
    for (int i = 0; i < 4; i++) send_word(40 - 10 * i, i == 3);
    wait_drained();

    // store overflow: the last word itself dropped, then several extra words dropped
    send_set(SET_CAP + 1);
    send_set(SET_CAP + 5);

    rand_words = 0;
    while (rand_words < RAND_TARGET) begin
      automatic int unsigned n = $urandom_range(1, 12);
      send_set(n);
      rand_words += n;
      if (rand_words < RAND_TARGET && $urandom_range(0, 9) == 0) wait_drained();
    end

    // drain and let the block settle
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/aesort_pkg.sv
sv/aesort_cell.sv
sv/ascending_exchange_sorter_core.sv
test/sort_check_pkg.sv
test/tb_top.sv
